// ===== src/jcc_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// jcc_pkg
// Shared types and codes for the JPEG completeness checker: actions,
// status codes, marker bytes and the walker state record.
// ----------------------------------------------------------------------------
package jcc_pkg;

  // Action codes carried with each input item.
  localparam logic [1:0] ACT_RESTART = 2'd0;
  localparam logic [1:0] ACT_BYTE    = 2'd1;
  localparam logic [1:0] ACT_END     = 2'd2;

  // Status codes reported with each result.
  localparam logic [2:0] ST_CHECKING   = 3'd0;
  localparam logic [2:0] ST_INTACT     = 3'd1;
  localparam logic [2:0] ST_TRUNCATED  = 3'd2;
  localparam logic [2:0] ST_NO_PREFIX  = 3'd3;
  localparam logic [2:0] ST_BAD_LENGTH = 3'd4;

  // Marker bytes.
  localparam logic [7:0] MK_PREFIX = 8'hFF;
  localparam logic [7:0] MK_SOS    = 8'hDA;
  localparam logic [7:0] MK_EOI    = 8'hD9;
  localparam logic [7:0] MK_TEM    = 8'h01;
  localparam logic [7:0] MK_RST_LO = 8'hD0;
  localparam logic [7:0] MK_RST_HI = 8'hD8;

  // Position in the marker walk.
  typedef enum logic [2:0] {
    PH_SOI_A,
    PH_SOI_B,
    PH_PREFIX,
    PH_CODE,
    PH_LEN_HI,
    PH_LEN_LO,
    PH_SKIP,
    PH_SCAN
  } phase_t;

  // Complete walker state.
  typedef struct packed {
    phase_t      phase;
    logic [7:0]  length_high;
    logic [15:0] skip_remaining;
    logic        prev_was_ff;
    logic [2:0]  verdict;
  } walk_state_t;

  localparam walk_state_t WALK_RESET = '{
    phase:          PH_SOI_A,
    length_high:    8'd0,
    skip_remaining: 16'd0,
    prev_was_ff:    1'b0,
    verdict:        ST_CHECKING
  };

endpackage

// ===== src/jcc_walker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// jcc_walker
// Holds the marker walk state and advances it by one transfer per cycle while step_en is high.
// The status after the step is presented combinationally for the queue.
// ----------------------------------------------------------------------------
module jcc_walker (
  input  logic       clk,
  input  logic       rst,
  input  logic       step_en,
  input  logic [1:0] action,
  input  logic [7:0] data_byte,
  output logic [2:0] status_next
);
  import jcc_pkg::*;

  walk_state_t state;
  walk_state_t state_next;
  walk_state_t byte_next;
  logic [15:0] seg_len;
  logic [15:0] skip_dec;

  assign seg_len  = {state.length_high, data_byte};
  assign skip_dec = (state.skip_remaining != 16'd0) ?
                    (state.skip_remaining - 16'd1) : state.skip_remaining;

  // Effect of one data byte on the walk.
  always_comb begin
    byte_next = state;
    case (state.phase)
      PH_SOI_A: byte_next.phase = PH_SOI_B;
      PH_SOI_B: byte_next.phase = PH_PREFIX;
      PH_PREFIX: begin
        if (data_byte != MK_PREFIX) begin
          byte_next.verdict = ST_NO_PREFIX;
        end else begin
          byte_next.phase = PH_CODE;
        end
      end
      PH_CODE: begin
        if (data_byte == MK_PREFIX) begin
          byte_next.phase = PH_CODE;
        end else if (data_byte == MK_SOS) begin
          byte_next.prev_was_ff = 1'b0;
          byte_next.phase       = PH_SCAN;
        end else if (data_byte == MK_EOI) begin
          byte_next.verdict = ST_TRUNCATED;
        end else if (data_byte == MK_TEM ||
                     (data_byte >= MK_RST_LO && data_byte <= MK_RST_HI)) begin
          byte_next.phase = PH_PREFIX;
        end else begin
          byte_next.phase = PH_LEN_HI;
        end
      end
      PH_LEN_HI: begin
        byte_next.length_high = data_byte;
        byte_next.phase       = PH_LEN_LO;
      end
      PH_LEN_LO: begin
        if (seg_len < 16'd2) begin
          byte_next.verdict = ST_BAD_LENGTH;
        end else if (seg_len == 16'd2) begin
          byte_next.phase = PH_PREFIX;
        end else begin
          byte_next.skip_remaining = seg_len - 16'd2;
          byte_next.phase          = PH_SKIP;
        end
      end
      PH_SKIP: begin
        byte_next.skip_remaining = skip_dec;
        if (skip_dec == 16'd0) begin
          byte_next.phase = PH_PREFIX;
        end
      end
      PH_SCAN: begin
        if (state.prev_was_ff && data_byte == MK_EOI) begin
          byte_next.verdict = ST_INTACT;
        end
        byte_next.prev_was_ff = (data_byte == MK_PREFIX);
      end
      default: byte_next.phase = PH_SOI_A;
    endcase
  end

  // Action decode; once a verdict is given only a restart changes the state.
  always_comb begin
    state_next = state;
    case (action)
      ACT_RESTART: state_next = WALK_RESET;
      ACT_BYTE: begin
        if (state.verdict == ST_CHECKING) begin
          state_next = byte_next;
        end
      end
      ACT_END: begin
        if (state.verdict == ST_CHECKING) begin
          state_next.verdict = ST_TRUNCATED;
        end
      end
      default: state_next = state;
    endcase
  end

  assign status_next = state_next.verdict;

  // State register, advanced on each accepted transfer.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= WALK_RESET;
    end else if (step_en) begin
      state <= state_next;
    end
  end

endmodule

// ===== src/jcc_result_q.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// jcc_result_q
// Two-entry result queue that decouples the input side from a stalled
// output, so a new transfer can be taken while a result waits.
// ----------------------------------------------------------------------------
module jcc_result_q (
  input  logic       clk,
  input  logic       rst,
  input  logic       push,
  input  logic [2:0] push_status,
  output logic       full,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [2:0] status
);
  import jcc_pkg::*;

  logic [2:0] entry [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  logic       pop;

  assign full      = (count == 2'd2);
  assign out_valid = (count != 2'd0);
  assign status    = entry[rd_ptr];
  assign pop       = out_valid && !out_stall;

  // Pointer and occupancy control.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      if (push && !pop) begin
        count <= count + 2'd1;
      end else if (pop && !push) begin
        count <= count - 2'd1;
      end
    end
  end

  // Result storage needs no reset.
  always_ff @(posedge clk) begin
    if (push) begin
      entry[wr_ptr] <= push_status;
    end
  end

endmodule

// ===== src/jpeg_completeness_checker_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// jpeg_completeness_checker_unit
// Byte-serial JPEG completeness checker with valid/stall channels.
// ----------------------------------------------------------------------------
// Takes one input transfer every cycle unless the input stalls, and returns
// exactly one status per transfer. The walk state updates at acceptance, when
// the status is also written into a two-entry result queue to wait there, and
// the input stalls only while that queue holds two results the output has not
// taken. Action 0 restarts for a new file, 1 carries a file byte, 2 marks the
// end of stream; status is the verdict after the transfer (0 still checking,
// 1 intact, 2 truncated, 3 marker prefix missing, 4 segment length invalid).
module jpeg_completeness_checker_unit (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [1:0] action,
  input  logic [7:0] data_byte,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [2:0] status
);
  import jcc_pkg::*;

  logic       accept;
  logic       q_full;
  logic [2:0] status_next;

  assign in_stall = q_full;
  assign accept   = in_valid && !in_stall;

  // Marker walk.
  jcc_walker u_walker (
    .clk         (clk),
    .rst         (rst),
    .step_en     (accept),
    .action      (action),
    .data_byte   (data_byte),
    .status_next (status_next)
  );

  // Result queue.
  jcc_result_q u_result_q (
    .clk         (clk),
    .rst         (rst),
    .push        (accept),
    .push_status (status_next),
    .full        (q_full),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .status      (status)
  );

endmodule

// ===== src/jcc_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// jcc_checker
// Port-level checks for the completeness checker, bound to the top level.
// ----------------------------------------------------------------------------
module jcc_checker (
  input logic       clk,
  input logic       rst,
  input logic       in_valid,
  input logic       in_stall,
  input logic [1:0] action,
  input logic       out_valid,
  input logic       out_stall,
  input logic [2:0] status
);
  import jcc_pkg::*;

  // A stalled result holds until it is taken.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(status))
    else $error("stalled result changed");

  // The input stalls only when results are waiting.
  a_stall_needs_result: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> out_valid)
    else $error("input stalled with no result pending");

  // A restart into an empty output shows checking on the next cycle.
  a_restart_status: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall && action == ACT_RESTART && !out_valid
    |=> out_valid && status == ST_CHECKING)
    else $error("restart did not report checking");

  // Reported status is always a defined code.
  a_status_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> status <= ST_BAD_LENGTH)
    else $error("status code out of range");

  // Nothing is pending right after reset.
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result pending after reset");

endmodule

bind jpeg_completeness_checker_unit jcc_checker u_jcc_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .action    (action),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .status    (status)
);

// ===== dv/tb_jpeg_completeness_checker_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_jpeg_completeness_checker_unit
// Self-checking bench for the byte-serial JPEG completeness checker.
// ----------------------------------------------------------------------------
// A short table of hand-written transfers covers the start-of-image bytes,
// fill bytes, length-free markers, a segment with no payload, the scan end, each
// error verdict, restart, end of stream and the unused action. Random files
// follow: mostly well-formed marker walks with random content, some cut short,
// corrupted or mixed with noise. A bench-side model of the marker walk
// predicts the status of every input transfer, and each output transfer is
// compared in order. Both channels idle at random.
module tb_jpeg_completeness_checker_unit;
  import jcc_pkg::*;

  // The action code that the block leaves without effect.
  localparam logic [1:0] ACT_UNUSED = 2'd3;
  localparam int DIRECTED_COUNT = 30;
  localparam int RANDOM_TARGET = 850;

  // One input transfer; the directed rows may carry a fixed expected status.
  typedef struct packed {
    logic [1:0] act;
    logic [7:0] data;
    logic       has_want;
    logic [2:0] want;
  } stim_item_t;

  localparam stim_item_t DIRECTED_ROWS [DIRECTED_COUNT] = '{
    // Start of image, then a length-free marker and fill bytes.
    '{ACT_BYTE,    8'hFF,     1'b0, ST_CHECKING},
    '{ACT_BYTE,    8'hD8,     1'b0, ST_CHECKING},
    '{ACT_BYTE,    MK_PREFIX, 1'b0, ST_CHECKING},
    '{ACT_BYTE,    MK_TEM,    1'b0, ST_CHECKING},
    '{ACT_BYTE,    MK_PREFIX, 1'b0, ST_CHECKING},
    '{ACT_BYTE,    MK_PREFIX, 1'b0, ST_CHECKING},
    '{ACT_BYTE,    MK_RST_HI, 1'b0, ST_CHECKING},
    // Segment whose length is exactly two, so no payload follows.
    '{ACT_BYTE,    MK_PREFIX, 1'b0, ST_CHECKING},
    '{ACT_BYTE,    8'hE0,     1'b0, ST_CHECKING},
    '{ACT_BYTE,    8'h00,     1'b0, ST_CHECKING},
    '{ACT_BYTE,    8'h02,     1'b0, ST_CHECKING},
    // Start of scan and the end-of-image pair.
    '{ACT_BYTE,    MK_PREFIX, 1'b0, ST_CHECKING},
    '{ACT_BYTE,    MK_SOS,    1'b0, ST_CHECKING},
    '{ACT_BYTE,    MK_PREFIX, 1'b0, ST_CHECKING},
    '{ACT_BYTE,    MK_EOI,    1'b1, ST_INTACT},
    // The verdict holds against an end mark and the unused action.
    '{ACT_END,     8'h00,     1'b1, ST_INTACT},
    '{ACT_UNUSED,  8'hFF,     1'b1, ST_INTACT},
    // Missing marker prefix.
    '{ACT_RESTART, 8'h00,     1'b1, ST_CHECKING},
    '{ACT_BYTE,    8'h00,     1'b0, ST_CHECKING},
    '{ACT_BYTE,    8'h00,     1'b0, ST_CHECKING},
    '{ACT_BYTE,    8'h7F,     1'b1, ST_NO_PREFIX},
    // Segment length below two.
    '{ACT_RESTART, 8'hFF,     1'b1, ST_CHECKING},
    '{ACT_BYTE,    8'h00,     1'b0, ST_CHECKING},
    '{ACT_BYTE,    8'h00,     1'b0, ST_CHECKING},
    '{ACT_BYTE,    MK_PREFIX, 1'b0, ST_CHECKING},
    '{ACT_BYTE,    8'hC4,     1'b0, ST_CHECKING},
    '{ACT_BYTE,    8'h00,     1'b0, ST_CHECKING},
    '{ACT_BYTE,    8'h01,     1'b1, ST_BAD_LENGTH},
    // Stream that ends before any verdict.
    '{ACT_RESTART, 8'h00,     1'b1, ST_CHECKING},
    '{ACT_END,     8'h00,     1'b1, ST_TRUNCATED}
  };

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       in_valid = 1'b0;
  logic       in_stall;
  logic [1:0] action = ACT_RESTART;
  logic [7:0] data_byte = 8'h00;
  logic       out_valid;
  logic       out_stall = 1'b0;
  logic [2:0] status;

  // Bench copy of the marker walk.
  phase_t      walk_phase;
  logic [7:0]  len_high_q;
  logic [15:0] bytes_to_skip;
  logic        last_was_ff;
  logic [2:0]  verdict_q;

  stim_item_t stim_q[$];
  logic [2:0] expected_status_q[$];
  logic [2:0] popped_status;
  int         error_count = 0;
  int         random_files = 0;
  int         status_seen [5] = '{0, 0, 0, 0, 0};
  int         stall_mode = 0;
  int         stall_mode_left = 0;

  jpeg_completeness_checker_unit dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .action    (action),
    .data_byte (data_byte),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .status    (status)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Prints one mismatch line and counts it.
  task automatic report_mismatch(input string what, input logic [2:0] got,
                                 input logic [2:0] want);
    $display("MISMATCH at %0t: %s, got %0d, expected %0d", $realtime, what, got, want);
    error_count++;
  endtask

  function automatic void reset_walk();
    walk_phase    = PH_SOI_A;
    len_high_q    = 8'h00;
    bytes_to_skip = 16'h0000;
    last_was_ff   = 1'b0;
    verdict_q     = ST_CHECKING;
  endfunction

  // Advances the bench walk by one input transfer and returns the new status.
  function automatic logic [2:0] advance_walk(input logic [1:0] act, input logic [7:0] b);
    logic [15:0] seg_len;
    seg_len = {len_high_q, b};
    if (act == ACT_RESTART) begin
      reset_walk();
    end else if (act == ACT_END) begin
      if (verdict_q == ST_CHECKING) verdict_q = ST_TRUNCATED;
    end else if (act == ACT_BYTE && verdict_q == ST_CHECKING) begin
      case (walk_phase)
        PH_SOI_A: walk_phase = PH_SOI_B;
        PH_SOI_B: walk_phase = PH_PREFIX;
        PH_PREFIX: begin
          if (b != MK_PREFIX) verdict_q = ST_NO_PREFIX;
          else walk_phase = PH_CODE;
        end
        PH_CODE: begin
          // Fill bytes keep the walk waiting for the marker code.
          if (b == MK_SOS) begin
            last_was_ff = 1'b0;
            walk_phase  = PH_SCAN;
          end else if (b == MK_EOI) begin
            verdict_q = ST_TRUNCATED;
          end else if (b == MK_TEM || (b >= MK_RST_LO && b <= MK_RST_HI)) begin
            walk_phase = PH_PREFIX;
          end else if (b != MK_PREFIX) begin
            walk_phase = PH_LEN_HI;
          end
        end
        PH_LEN_HI: begin
          len_high_q = b;
          walk_phase = PH_LEN_LO;
        end
        PH_LEN_LO: begin
          if (seg_len < 16'd2) begin
            verdict_q = ST_BAD_LENGTH;
          end else if (seg_len == 16'd2) begin
            walk_phase = PH_PREFIX;
          end else begin
            bytes_to_skip = seg_len - 16'd2;
            walk_phase    = PH_SKIP;
          end
        end
        PH_SKIP: begin
          if (bytes_to_skip != 16'd0) bytes_to_skip = bytes_to_skip - 16'd1;
          if (bytes_to_skip == 16'd0) walk_phase = PH_PREFIX;
        end
        PH_SCAN: begin
          if (last_was_ff && b == MK_EOI) verdict_q = ST_INTACT;
          last_was_ff = (b == MK_PREFIX);
        end
        default: walk_phase = PH_SOI_A;
      endcase
    end
    return verdict_q;
  endfunction

  function automatic void add_item(input logic [1:0] act, input logic [7:0] b);
    stim_q.push_back('{act, b, 1'b0, ST_CHECKING});
  endfunction

  // Appends one random file: a marker walk with random segments and scan data,
  // sometimes cut short, corrupted, padded with noise or followed by trailers.
  task automatic add_random_file();
    int         start_idx;
    int         seg_len;
    int         flaw;
    int         pos;
    logic [7:0] code;
    stim_item_t hit;
    start_idx = stim_q.size();
    add_item(ACT_RESTART, 8'($urandom));
    add_item(ACT_BYTE, 8'($urandom));
    add_item(ACT_BYTE, 8'($urandom));
    repeat ($urandom_range(0, 4)) begin
      add_item(ACT_BYTE, MK_PREFIX);
      repeat (($urandom_range(0, 3) == 0) ? $urandom_range(1, 2) : 0)
        add_item(ACT_BYTE, MK_PREFIX);
      if ($urandom_range(0, 3) == 0) begin
        add_item(ACT_BYTE, ($urandom_range(0, 1) == 1) ? MK_TEM
                           : MK_RST_LO + 8'($urandom_range(0, 8)));
      end else begin
        // Any code that carries a length.
        do code = 8'($urandom);
        while (code == MK_PREFIX || code == MK_SOS || code == MK_EOI || code == MK_TEM ||
               (code >= MK_RST_LO && code <= MK_RST_HI));
        case ($urandom_range(0, 19))
          0:       seg_len = $urandom_range(0, 1);
          1:       seg_len = $urandom_range(256, 300);
          default: seg_len = $urandom_range(2, 10);
        endcase
        add_item(ACT_BYTE, code);
        add_item(ACT_BYTE, 8'(seg_len >> 8));
        add_item(ACT_BYTE, 8'(seg_len));
        repeat ((seg_len > 2) ? seg_len - 2 : 0) add_item(ACT_BYTE, 8'($urandom));
      end
    end
    // Scan data, with prefix bytes common so that near misses of the end pair occur.
    add_item(ACT_BYTE, MK_PREFIX);
    add_item(ACT_BYTE, MK_SOS);
    repeat ($urandom_range(0, 12))
      add_item(ACT_BYTE, ($urandom_range(0, 3) == 0) ? MK_PREFIX : 8'($urandom));
    add_item(ACT_BYTE, MK_PREFIX);
    add_item(ACT_BYTE, MK_EOI);

    flaw = $urandom_range(0, 9);
    if (flaw <= 1) begin
      pos = $urandom_range(start_idx + 1, stim_q.size() - 1);
      while (stim_q.size() > pos) void'(stim_q.pop_back());
      add_item(ACT_END, 8'($urandom));
    end else if (flaw <= 3) begin
      pos = $urandom_range(start_idx + 1, stim_q.size() - 1);
      hit = stim_q[pos];
      case ($urandom_range(0, 5))
        0:       hit.data = 8'h00;
        1:       hit.data = 8'h01;
        2:       hit.data = MK_EOI;
        3:       hit.data = MK_PREFIX;
        4:       hit.data = MK_SOS;
        default: hit.data = 8'($urandom);
      endcase
      stim_q[pos] = hit;
    end else if (flaw == 4) begin
      repeat ($urandom_range(1, 6)) add_item(2'($urandom_range(0, 3)), 8'($urandom));
    end
    if ($urandom_range(0, 2) == 0) begin
      repeat ($urandom_range(1, 3)) add_item(ACT_BYTE, 8'($urandom));
      add_item(($urandom_range(0, 1) == 1) ? ACT_END : ACT_UNUSED, 8'($urandom));
    end
    random_files++;
  endtask

  // Stimulus: reset, then the directed table and the random files with bursts and gaps.
  initial begin
    int         accepted;
    int         next_idx;
    int         burst_left;
    int         gap_left;
    stim_item_t cur;
    logic [2:0] predicted;
    reset_walk();
    for (int i = 0; i < DIRECTED_COUNT; i++) stim_q.push_back(DIRECTED_ROWS[i]);
    while (stim_q.size() < DIRECTED_COUNT + RANDOM_TARGET) add_random_file();

    repeat (5) @(posedge clk);
    rst <= 1'b0;

    accepted   = 0;
    next_idx   = 0;
    burst_left = $urandom_range(1, 16);
    gap_left   = 0;
    while (accepted < stim_q.size()) begin
      @(posedge clk);
      if (in_valid && !in_stall) begin
        cur       = stim_q[accepted];
        predicted = advance_walk(cur.act, cur.data);
        expected_status_q.push_back(cur.has_want ? cur.want : predicted);
        accepted++;
      end
      // A stalled transfer holds; otherwise present the next item or idle.
      if (!(in_valid && in_stall)) begin
        if (gap_left > 0) begin
          in_valid <= 1'b0;
          gap_left--;
        end else if (next_idx < stim_q.size()) begin
          in_valid  <= 1'b1;
          action    <= stim_q[next_idx].act;
          data_byte <= stim_q[next_idx].data;
          next_idx++;
          burst_left--;
          if (burst_left == 0) begin
            burst_left = $urandom_range(1, 16);
            gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 5);
          end
        end else begin
          in_valid <= 1'b0;
        end
      end
    end

    while (expected_status_q.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);

    $display("Covered %0d directed and %0d random transfers over %0d random files.",
             DIRECTED_COUNT, stim_q.size() - DIRECTED_COUNT, random_files);
    $display({"Status transfers: %0d checking, %0d intact, %0d truncated, ",
              "%0d no prefix, %0d bad length."},
             status_seen[0], status_seen[1], status_seen[2], status_seen[3], status_seen[4]);
    if (error_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  // Output side: check each status transfer in order, stall in changing patterns.
  always @(posedge clk) begin
    if (!rst) begin
      if (out_valid && !out_stall) begin
        if (expected_status_q.size() == 0) begin
          report_mismatch("status transfer with nothing pending", status, 3'bx);
        end else begin
          popped_status = expected_status_q.pop_front();
          if (status !== popped_status) report_mismatch("status", status, popped_status);
        end
        if (status <= ST_BAD_LENGTH) status_seen[status]++;
      end
      if (stall_mode_left == 0) begin
        stall_mode      = $urandom_range(0, 2);
        stall_mode_left = $urandom_range(16, 64);
      end else begin
        stall_mode_left--;
      end
      case (stall_mode)
        0:       out_stall <= 1'b0;
        1:       out_stall <= ($urandom_range(0, 3) == 0);
        default: out_stall <= ($urandom_range(0, 3) != 0);
      endcase
    end
  end

  // Run limit, far above the slowest correct run.
  initial begin
    #2000000;
    $display("Some tests failed");
    $finish;
  end

endmodule

// ===== files.f =====
src/jcc_pkg.sv
src/jcc_walker.sv
src/jcc_result_q.sv
src/jpeg_completeness_checker_unit.sv
src/jcc_checker.sv
dv/tb_jpeg_completeness_checker_unit.sv
